@@ src/elgamal_encrypt_decrypt_macros.svh @@
// Assertion macros shared by the ElGamal engine RTL.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef ELGAMAL_ENCRYPT_DECRYPT_MACROS_SVH
`define ELGAMAL_ENCRYPT_DECRYPT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ELG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ELG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/elg_pkg.sv @@
// Package for the ElGamal engine: data width, register indexes, modular add/sub.
// No dependencies.
package elg_pkg;

   localparam int W     = 32;
   localparam int W_LOG = $clog2(W);
   localparam int IDX_W = 8;

   typedef logic [W-1:0]     word_type;
   typedef logic [W_LOG-1:0] count_type;
   typedef logic [IDX_W-1:0] index_type;

   localparam index_type REG_MODULUS   = 8'd0;
   localparam index_type REG_GENERATOR = 8'd1;
   localparam index_type REG_SECRET    = 8'd2;
   localparam index_type REG_PUBLIC    = 8'd3;

   localparam word_type GEN_RESET = 32'd2;

   // (a + b) mod m with a, b below m
   function automatic word_type add_mod(input word_type a, input word_type b,
                                        input word_type m);
      logic [W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[W-1:0];
   endfunction

   // (a - b) mod m with a, b below m; wraparound absorbs the add of m
   function automatic word_type sub_mod(input word_type a, input word_type b,
                                        input word_type m);
      word_type d;
      d = a - b;
      if (a < b) begin
         d = d + m;
      end
      return d;
   endfunction

endpackage

@@ src/elg_mulmod.sv @@
// Bit-serial modular multiplier: product = (op_a * op_b) mod modulus.
// op_a must be below modulus; op_b may hold any bits. Uses elg_pkg.
module elg_mulmod (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  elg_pkg::word_type op_a,
   input  elg_pkg::word_type op_b,
   input  elg_pkg::word_type modulus,
   output logic              done,
   output elg_pkg::word_type product
);
   import elg_pkg::*;

   logic      busy_ff;
   logic      phase_ff;
   logic      done_ff;
   count_type cnt_ff;
   word_type  acc_ff;
   word_type  a_ff;
   word_type  b_ff;
   word_type  m_ff;

   // Double the accumulator, then add the addend when the top multiplier bit is set
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            phase_ff <= 1'b0;
            cnt_ff   <= '0;
            acc_ff   <= '0;
            a_ff     <= op_a;
            b_ff     <= op_b;
            m_ff     <= modulus;
         end else if (busy_ff) begin
            if (!phase_ff) begin
               acc_ff   <= add_mod(acc_ff, acc_ff, m_ff);
               phase_ff <= 1'b1;
            end else begin
               if (b_ff[W-1]) begin
                  acc_ff <= add_mod(acc_ff, a_ff, m_ff);
               end
               b_ff     <= {b_ff[W-2:0], 1'b0};
               phase_ff <= 1'b0;
               cnt_ff   <= cnt_ff + 1'b1;
               if (cnt_ff == count_type'(W-1)) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

@@ src/elgamal_encrypt_decrypt.sv @@
// ElGamal encrypt/decrypt engine top level: config registers, sequencer, divider.
// Depends on elg_pkg, elg_mulmod and elgamal_encrypt_decrypt_macros.svh.
//
// Usage:
//   csr_ channel writes p (index 0), g (1), x (2), y (3); other indexes are
//   dropped. csr_ready is always high. Write only while the engine is idle.
//   req_ channel takes one beat per request: req_type 0 encrypts req_message
//   with req_ephemeral_key, 1 decrypts req_cipher_first/req_cipher_second.
//   rsp_ channel returns one beat per request: c1 (zero on decrypt), c2 or the
//   plaintext, and rsp_fault when p is below two or no inverse exists.
// Sequence: every modular multiply runs one multiplier bit at a time, a doubling
//   then a conditional add, through the shared serial multiplier. An exponent
//   costs 32 squarings plus one multiply per set bit. Encrypt runs two powers
//   and a multiply. Decrypt runs one power, a Euclid loop of up to about 47
//   rounds of a bit-serial division plus a multiply, then a final multiply.
//   One request is in flight at a time; a faulting modulus skips the arithmetic
//   and goes straight to the response.
// Reset: registers return to p = 0, g = 2, x = 0, y = 0; no beat is pending.
// Stall: a held result sits in the output register; the next request is
//   accepted meanwhile and its result waits until the held beat is taken.
`include "elgamal_encrypt_decrypt_macros.svh"

module elgamal_encrypt_decrypt (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  elg_pkg::index_type  csr_index,
   input  elg_pkg::word_type   csr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  elg_pkg::word_type   req_message,
   input  elg_pkg::word_type   req_ephemeral_key,
   input  elg_pkg::word_type   req_cipher_first,
   input  elg_pkg::word_type   req_cipher_second,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output elg_pkg::word_type   rsp_out_first,
   output elg_pkg::word_type   rsp_out_second,
   output logic                rsp_fault
);
   import elg_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_RED, S_PBIT, S_PMUL, S_PSQ, S_ECHK, S_DIV, S_EMUL, S_FIN, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      STG_ENC_G, STG_ENC_Y, STG_DEC
   } stage_type;

   // Configuration registers
   word_type p_ff, g_ff, x_ff, y_ff;

   state_type state_ff;
   stage_type stage_ff;
   count_type cnt_ff;
   word_type  k_ff, m_ff, e_ff, base_ff, r_ff;
   word_type  r0_ff, r1_ff, t0_ff, t1_ff, dq_ff;
   word_type  rem_ff;
   word_type  first_ff, second_ff;
   logic      fault_ff;

   logic      rsp_valid_ff;
   word_type  rsp_out_first_ff, rsp_out_second_ff;
   logic      rsp_fault_ff;

   logic      mm_start_ff;
   word_type  mm_a_ff, mm_b_ff;
   logic      mm_done;
   word_type  mm_product;

   logic [W:0] div_trial;

   elg_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start_ff),
      .op_a    (mm_a_ff),
      .op_b    (mm_b_ff),
      .modulus (p_ff),
      .done    (mm_done),
      .product (mm_product)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);

   // Restoring division step: bring down the next dividend bit
   assign div_trial = {rem_ff, dq_ff[W-1]};

   // Store configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff <= '0;
         g_ff <= GEN_RESET;
         x_ff <= '0;
         y_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MODULUS:   p_ff <= csr_data;
            REG_GENERATOR: g_ff <= csr_data;
            REG_SECRET:    x_ff <= csr_data;
            REG_PUBLIC:    y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Sequence powers, Euclid rounds and final multiply; hold the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stage_ff     <= STG_ENC_G;
         mm_start_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         mm_start_ff <= 1'b0;
         // Drop the taken beat unless a new one replaces it this cycle
         if (rsp_valid_ff && rsp_ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  first_ff  <= '0;
                  second_ff <= '0;
                  fault_ff  <= 1'b0;
                  k_ff      <= req_ephemeral_key;
                  m_ff      <= req_type ? req_cipher_second : req_message;
                  e_ff      <= req_type ? x_ff : req_ephemeral_key;
                  r_ff      <= word_type'(1);
                  cnt_ff    <= '0;
                  stage_ff  <= req_type ? STG_DEC : STG_ENC_G;
                  if (p_ff < word_type'(2)) begin
                     fault_ff <= 1'b1;
                     state_ff <= S_OUT;
                  end else begin
                     mm_a_ff     <= word_type'(1);
                     mm_b_ff     <= req_type ? req_cipher_first : g_ff;
                     mm_start_ff <= 1'b1;
                     state_ff    <= S_RED;
                  end
               end
            end
            S_RED: begin
               if (mm_done) begin
                  base_ff  <= mm_product;
                  state_ff <= S_PBIT;
               end
            end
            S_PBIT: begin
               mm_start_ff <= 1'b1;
               if (e_ff[0]) begin
                  mm_a_ff  <= r_ff;
                  mm_b_ff  <= base_ff;
                  state_ff <= S_PMUL;
               end else begin
                  mm_a_ff  <= base_ff;
                  mm_b_ff  <= base_ff;
                  state_ff <= S_PSQ;
               end
            end
            S_PMUL: begin
               if (mm_done) begin
                  r_ff        <= mm_product;
                  mm_a_ff     <= base_ff;
                  mm_b_ff     <= base_ff;
                  mm_start_ff <= 1'b1;
                  state_ff    <= S_PSQ;
               end
            end
            S_PSQ: begin
               if (mm_done) begin
                  base_ff <= mm_product;
                  cnt_ff  <= cnt_ff + 1'b1;
                  if (cnt_ff == count_type'(W-1)) begin
                     unique case (stage_ff)
                        STG_ENC_G: begin
                           first_ff    <= r_ff;
                           stage_ff    <= STG_ENC_Y;
                           r_ff        <= word_type'(1);
                           e_ff        <= k_ff;
                           mm_a_ff     <= word_type'(1);
                           mm_b_ff     <= y_ff;
                           mm_start_ff <= 1'b1;
                           state_ff    <= S_RED;
                        end
                        STG_ENC_Y: begin
                           mm_a_ff     <= r_ff;
                           mm_b_ff     <= m_ff;
                           mm_start_ff <= 1'b1;
                           state_ff    <= S_FIN;
                        end
                        default: begin
                           r0_ff    <= p_ff;
                           r1_ff    <= r_ff;
                           t0_ff    <= '0;
                           t1_ff    <= word_type'(1);
                           state_ff <= S_ECHK;
                        end
                     endcase
                  end else begin
                     e_ff     <= e_ff >> 1;
                     state_ff <= S_PBIT;
                  end
               end
            end
            S_ECHK: begin
               if (r1_ff == '0) begin
                  if (r0_ff == word_type'(1)) begin
                     mm_a_ff     <= t0_ff;
                     mm_b_ff     <= m_ff;
                     mm_start_ff <= 1'b1;
                     state_ff    <= S_FIN;
                  end else begin
                     fault_ff <= 1'b1;
                     state_ff <= S_OUT;
                  end
               end else begin
                  dq_ff    <= r0_ff;
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_trial >= {1'b0, r1_ff}) begin
                  rem_ff <= word_type'(div_trial - {1'b0, r1_ff});
                  dq_ff  <= {dq_ff[W-2:0], 1'b1};
               end else begin
                  rem_ff <= div_trial[W-1:0];
                  dq_ff  <= {dq_ff[W-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == count_type'(W-1)) begin
                  state_ff <= S_EMUL;
               end
               // Issue q * t1 once the quotient is complete
               if (cnt_ff == count_type'(W-1)) begin
                  mm_a_ff     <= t1_ff;
                  mm_b_ff     <= (div_trial >= {1'b0, r1_ff}) ?
                                 {dq_ff[W-2:0], 1'b1} : {dq_ff[W-2:0], 1'b0};
                  mm_start_ff <= 1'b1;
               end
            end
            S_EMUL: begin
               if (mm_done) begin
                  r0_ff    <= r1_ff;
                  r1_ff    <= rem_ff;
                  t0_ff    <= t1_ff;
                  t1_ff    <= sub_mod(t0_ff, mm_product, p_ff);
                  state_ff <= S_ECHK;
               end
            end
            S_FIN: begin
               if (mm_done) begin
                  second_ff <= mm_product;
                  state_ff  <= S_OUT;
               end
            end
            S_OUT: begin
               // Load the output register once the held beat is gone
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_fault_ff      <= fault_ff;
                  rsp_out_first_ff  <= (fault_ff || stage_ff == STG_DEC) ? '0 : first_ff;
                  rsp_out_second_ff <= fault_ff ? '0 : second_ff;
                  state_ff          <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_first  = rsp_out_first_ff;
   assign rsp_out_second = rsp_out_second_ff;
   assign rsp_fault      = rsp_fault_ff;

   `ELG_ASSERT_SAME(a_fault_clears, rsp_valid_ff && rsp_fault_ff, rsp_out_first_ff == '0 && rsp_out_second_ff == '0, "fault beat carries data")
   `ELG_ASSERT_NEXT(a_accept_busy, req_valid && req_ready, state_ff != S_IDLE, "request accepted but sequencer idle")
   `ELG_ASSERT_SAME(a_done_waits, mm_done, state_ff == S_RED || state_ff == S_PMUL || state_ff == S_PSQ || state_ff == S_EMUL || state_ff == S_FIN, "multiply finished outside a wait state")

endmodule
